FILE: hdl/i2r_pkg.sv
// ----------------------------------------------------------------------------
// i2r_pkg
// shared types, letter codes and numeral helpers for the roman numeral block
// ----------------------------------------------------------------------------
`default_nettype none

package i2r_pkg;

  localparam int SYM_W = 7;
  localparam int DIG_W = 4;
  localparam int NUM_PLACES = 4;
  localparam int VALUE_W = 12;

  localparam logic [VALUE_W-1:0] VALUE_MIN = 12'd1;
  localparam logic [VALUE_W-1:0] VALUE_MAX = 12'd3999;

  localparam logic [SYM_W-1:0] SYM_NONE = 7'h00;
  localparam logic [SYM_W-1:0] SYM_I = 7'h49;
  localparam logic [SYM_W-1:0] SYM_V = 7'h56;
  localparam logic [SYM_W-1:0] SYM_X = 7'h58;
  localparam logic [SYM_W-1:0] SYM_L = 7'h4c;
  localparam logic [SYM_W-1:0] SYM_C = 7'h43;
  localparam logic [SYM_W-1:0] SYM_D = 7'h44;
  localparam logic [SYM_W-1:0] SYM_M = 7'h4d;

  // decimal places, thousands on top
  localparam logic [1:0] PLACE_UNITS = 2'd0;
  localparam logic [1:0] PLACE_TENS = 2'd1;
  localparam logic [1:0] PLACE_HUNDREDS = 2'd2;
  localparam logic [1:0] PLACE_THOUSANDS = 2'd3;

  typedef logic [NUM_PLACES-1:0][DIG_W-1:0] digits_t;

  // one classified item between front and back
  typedef struct packed {
    logic    err;
    digits_t digit;
  } entry_t;

  // number of characters a digit produces at a place
  function automatic logic [2:0] char_len(input logic [1:0] place, input logic [3:0] d);
    logic [2:0] n;
    n = 3'd0;
    if (place == PLACE_THOUSANDS) begin
      n = d[2:0];
    end else begin
      case (d)
        4'd0: n = 3'd0;
        4'd1: n = 3'd1;
        4'd2: n = 3'd2;
        4'd3: n = 3'd3;
        4'd4: n = 3'd2;
        4'd5: n = 3'd1;
        4'd6: n = 3'd2;
        4'd7: n = 3'd3;
        4'd8: n = 3'd4;
        4'd9: n = 3'd2;
        default: n = 3'd0;
      endcase
    end
    return n;
  endfunction

  // character at position pos of a digit's run
  function automatic logic [SYM_W-1:0] char_at(input logic [1:0] place, input logic [3:0] d,
                                               input logic [1:0] pos);
    logic [SYM_W-1:0] one;
    logic [SYM_W-1:0] five;
    logic [SYM_W-1:0] ten;
    logic [SYM_W-1:0] ch;
    one = SYM_M;
    five = SYM_NONE;
    ten = SYM_NONE;
    case (place)
      PLACE_UNITS: begin
        one = SYM_I; five = SYM_V; ten = SYM_X;
      end
      PLACE_TENS: begin
        one = SYM_X; five = SYM_L; ten = SYM_C;
      end
      PLACE_HUNDREDS: begin
        one = SYM_C; five = SYM_D; ten = SYM_M;
      end
      default: begin
        one = SYM_M; five = SYM_NONE; ten = SYM_NONE;
      end
    endcase
    if (place == PLACE_THOUSANDS || d < 4'd4) begin
      ch = one;
    end else if (d == 4'd4) begin
      ch = (pos == 2'd0) ? one : five;
    end else if (d < 4'd9) begin
      ch = (pos == 2'd0) ? five : one;
    end else begin
      ch = (pos == 2'd0) ? one : ten;
    end
    return ch;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/i2r_front.sv
// ----------------------------------------------------------------------------
// i2r_front
// two-stage range check and decimal digit split feeding the item queue
// ----------------------------------------------------------------------------
`default_nettype none

module i2r_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [11:0]         in_value,
  input  wire logic                q_full,
  output logic                     q_push,
  output i2r_pkg::entry_t          q_entry
);

  // digit of r at weight w, r below ten times w
  function automatic logic [3:0] dec_digit(input logic [11:0] r, input logic [15:0] w);
    logic [3:0] d;
    d = 4'd0;
    for (int k = 1; k <= 9; k++) begin
      if ({4'd0, r} >= 16'(k) * w) d = 4'(k);
    end
    return d;
  endfunction

  logic        s1_v_r, s1_v_nxt;
  logic        s1_err_r;
  logic [3:0]  s1_th_r;
  logic [9:0]  s1_rem_r;
  logic        s2_v_r, s2_v_nxt;
  logic        s2_err_r;
  logic [3:0]  s2_th_r;
  logic [3:0]  s2_hun_r;
  logic [6:0]  s2_rem_r;

  logic        s1_ready, s2_ready;
  logic [3:0]  th, hun, tens;
  logic [15:0] rem1, rem2, rem3;

  assign s2_ready = !s2_v_r || !q_full;
  assign s1_ready = !s1_v_r || s2_ready;
  assign in_stall = !s1_ready;
  assign q_push   = s2_v_r && !q_full;

  always_comb begin
    th   = dec_digit(in_value, 16'd1000);
    rem1 = {4'd0, in_value} - 16'(th) * 16'd1000;
    hun  = dec_digit({2'd0, s1_rem_r}, 16'd100);
    rem2 = {6'd0, s1_rem_r} - 16'(hun) * 16'd100;
    tens = dec_digit({5'd0, s2_rem_r}, 16'd10);
    rem3 = {9'd0, s2_rem_r} - 16'(tens) * 16'd10;
  end

  always_comb begin
    q_entry.err = s2_err_r;
    q_entry.digit[i2r_pkg::PLACE_THOUSANDS] = s2_th_r;
    q_entry.digit[i2r_pkg::PLACE_HUNDREDS]  = s2_hun_r;
    q_entry.digit[i2r_pkg::PLACE_TENS]      = tens;
    q_entry.digit[i2r_pkg::PLACE_UNITS]     = rem3[3:0];
  end

  always_comb begin
    s1_v_nxt = s1_ready ? in_valid : s1_v_r;
    s2_v_nxt = s2_ready ? s1_v_r : s2_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_err_r <= (in_value < i2r_pkg::VALUE_MIN) || (in_value > i2r_pkg::VALUE_MAX);
      s1_th_r  <= th;
      s1_rem_r <= rem1[9:0];
    end
    if (s2_ready) begin
      s2_err_r <= s1_err_r;
      s2_th_r  <= s1_th_r;
      s2_hun_r <= hun;
      s2_rem_r <= rem2[6:0];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/i2r_queue.sv
// ----------------------------------------------------------------------------
// i2r_queue
// small fifo of classified items between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module i2r_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire i2r_pkg::entry_t  push_entry,
  output logic                  full,
  input  wire logic             pop,
  output logic                  head_valid,
  output i2r_pkg::entry_t       head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  i2r_pkg::entry_t mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign full       = (cnt_r == CW'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/i2r_back.sv
// ----------------------------------------------------------------------------
// i2r_back
// character sequencer: walks one item's digits, one character per unstalled cycle
// ----------------------------------------------------------------------------
`default_nettype none

module i2r_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             head_valid,
  input  wire i2r_pkg::entry_t  head,
  output logic                  pop,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [6:0]            out_symbol,
  output logic                  out_last,
  output logic                  out_error
);

  logic             act_r, act_nxt;
  logic             err_r;
  i2r_pkg::digits_t dig_r;
  logic [1:0]       place_r;
  logic [1:0]       pos_r;
  logic             out_valid_r, out_valid_nxt;
  logic [6:0]       out_symbol_r;
  logic             out_last_r;
  logic             out_error_r;

  logic             cur_valid, cur_err;
  i2r_pkg::digits_t cur_dig;
  logic [1:0]       cur_place, cur_pos, head_place, low_place;
  logic [3:0]       d;
  logic [2:0]       len;
  logic             dig_end, has_lower, is_last, fire;
  logic [6:0]       sym;

  // highest place holding a nonzero digit
  always_comb begin
    head_place = i2r_pkg::PLACE_UNITS;
    for (int p = 0; p < i2r_pkg::NUM_PLACES; p++) begin
      if (head.digit[p] != '0) head_place = 2'(p);
    end
  end

  always_comb begin
    if (act_r) begin
      cur_err   = err_r;
      cur_dig   = dig_r;
      cur_place = place_r;
      cur_pos   = pos_r;
    end else begin
      cur_err   = head.err;
      cur_dig   = head.digit;
      cur_place = head_place;
      cur_pos   = 2'd0;
    end
    cur_valid = act_r || head_valid;
    d         = cur_dig[cur_place];
    len       = i2r_pkg::char_len(cur_place, d);
    dig_end   = ({1'b0, cur_pos} == len - 3'd1);
    sym       = cur_err ? i2r_pkg::SYM_NONE : i2r_pkg::char_at(cur_place, d, cur_pos);
  end

  // next nonzero digit below the current place
  always_comb begin
    has_lower = 1'b0;
    low_place = i2r_pkg::PLACE_UNITS;
    for (int p = 0; p < i2r_pkg::NUM_PLACES - 1; p++) begin
      if (2'(p) < cur_place && cur_dig[p] != '0) begin
        has_lower = 1'b1;
        low_place = 2'(p);
      end
    end
  end

  always_comb begin
    fire          = cur_valid && (!out_valid_r || !out_stall);
    is_last       = cur_err || (dig_end && !has_lower);
    pop           = fire && !act_r;
    act_nxt       = fire ? !is_last : act_r;
    out_valid_nxt = fire ? 1'b1 : (out_stall ? out_valid_r : 1'b0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      act_r       <= act_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      err_r        <= cur_err;
      dig_r        <= cur_dig;
      place_r      <= dig_end ? low_place : cur_place;
      pos_r        <= dig_end ? 2'd0 : cur_pos + 2'd1;
      out_symbol_r <= sym;
      out_last_r   <= is_last;
      out_error_r  <= cur_err;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_symbol = out_symbol_r;
  assign out_last   = out_last_r;
  assign out_error  = out_error_r;

endmodule

`default_nettype wire

FILE: hdl/integer_to_roman_numeral.sv
// path: an accepted item passes both front stages, the queue and the output register
// throughput: one character per cycle while out_stall is low; an item's numeral has
//   from 1 to 15 characters, with no gap between consecutive items
// the character sequencer's single output register sets that rate
// reset: rst_n low at a clock edge empties the front stages, the queue and the output
// ----------------------------------------------------------------------------
// integer_to_roman_numeral
// converts a 12-bit integer into its roman numeral, one ascii character per item
// ----------------------------------------------------------------------------
`default_nettype none

module integer_to_roman_numeral #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [11:0] in_value,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [6:0]       out_symbol,
  output logic             out_last,
  output logic             out_error
);

  // front to queue
  logic            q_full;
  logic            q_push;
  i2r_pkg::entry_t q_entry;

  // queue to back
  logic            q_pop;
  logic            q_head_valid;
  i2r_pkg::entry_t q_head;

  // front: range check plus thousands, hundreds, tens and units split,
  // two pipeline stages, stalls only when the queue is full
  i2r_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_value (in_value),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (q_entry)
  );

  // short queue so a long numeral on the output does not hold up the front
  i2r_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  // back: walks the digits, most significant first, skipping zero digits;
  // the first character of an item comes straight from the queue head,
  // which is popped at that moment, so items follow without a bubble
  i2r_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head       (q_head),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_symbol (out_symbol),
    .out_last   (out_last),
    .out_error  (out_error)
  );

endmodule

`default_nettype wire

FILE: hdl/i2r_checker.sv
// ----------------------------------------------------------------------------
// i2r_checker
// port-level checks on the roman numeral block, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module i2r_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic [11:0] in_value,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [6:0]  out_symbol,
  input wire logic        out_last,
  input wire logic        out_error
);

  // output empty right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // a stalled input item is still offered unchanged
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_value))
    else $error("stalled input item changed");

  // a stalled item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_symbol) && $stable(out_last)
      && $stable(out_error))
    else $error("stalled output item changed");

  // an out-of-range value gives a lone zero character
  a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error |-> out_last && out_symbol == i2r_pkg::SYM_NONE)
    else $error("bad error item");

  // a good character is one of the seven letters
  a_letter: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_error |-> out_symbol == i2r_pkg::SYM_I || out_symbol == i2r_pkg::SYM_V
      || out_symbol == i2r_pkg::SYM_X || out_symbol == i2r_pkg::SYM_L
      || out_symbol == i2r_pkg::SYM_C || out_symbol == i2r_pkg::SYM_D
      || out_symbol == i2r_pkg::SYM_M)
    else $error("character is not a roman letter");

endmodule

bind integer_to_roman_numeral i2r_checker u_i2r_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .in_value   (in_value),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_symbol (out_symbol),
  .out_last   (out_last),
  .out_error  (out_error)
);

`default_nettype wire

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// checks integer_to_roman_numeral: every accepted value is spelled out in
// the scoreboard and each character leaving the block is compared against it
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_HALF = 6;
  localparam int RESET_CYCLES = 7;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 300;    // long receiver hold-off for back-pressure
  localparam int DRAIN_CYCLES = 16;    // extra wait after the last owed character to catch stray output
  localparam int REPORT_CAP = 60;      // keep a broken run from flooding the log

  // one character of a numeral as it should leave the block
  typedef struct {
    logic [i2r_pkg::SYM_W-1:0] symbol;
    logic                      last;
    logic                      error;
  } numeral_char_t;

  // spells accepted values into a queue of characters owed by the block
  class numeral_board;
    numeral_char_t owed[$];
    int fails;
    int reports;

    function new();
      fails = 0;
      reports = 0;
    endfunction

    function void note_value(logic [i2r_pkg::VALUE_W-1:0] v);
      logic [i2r_pkg::SYM_W-1:0] run[$];
      logic [i2r_pkg::SYM_W-1:0] one;
      logic [i2r_pkg::SYM_W-1:0] five;
      logic [i2r_pkg::SYM_W-1:0] ten;
      numeral_char_t ch;
      int d;
      int p;
      if (v < i2r_pkg::VALUE_MIN || v > i2r_pkg::VALUE_MAX) begin
        ch.symbol = i2r_pkg::SYM_NONE;
        ch.last = 1'b1;
        ch.error = 1'b1;
        owed.insert(owed.size(), ch);
        return;
      end
      repeat (v / 1000) run.insert(run.size(), i2r_pkg::SYM_M);
      for (p = 2; p >= 0; p--) begin
        case (p)
          2: begin
            one = i2r_pkg::SYM_C; five = i2r_pkg::SYM_D; ten = i2r_pkg::SYM_M;
            d = int'((v / 12'd100) % 12'd10);
          end
          1: begin
            one = i2r_pkg::SYM_X; five = i2r_pkg::SYM_L; ten = i2r_pkg::SYM_C;
            d = int'((v / 12'd10) % 12'd10);
          end
          default: begin
            one = i2r_pkg::SYM_I; five = i2r_pkg::SYM_V; ten = i2r_pkg::SYM_X;
            d = int'(v % 12'd10);
          end
        endcase
        if (d == 4) begin
          run.insert(run.size(), one);
          run.insert(run.size(), five);
        end else if (d == 9) begin
          run.insert(run.size(), one);
          run.insert(run.size(), ten);
        end else begin
          if (d >= 5) run.insert(run.size(), five);
          repeat (d % 5) run.insert(run.size(), one);
        end
      end
      foreach (run[i]) begin
        ch.symbol = run[i];
        ch.last = (i == run.size() - 1);
        ch.error = 1'b0;
        owed.insert(owed.size(), ch);
      end
    endfunction

    function void complain(string what, int exp_val, int act_val);
      fails++;
      reports++;
      if (reports <= REPORT_CAP)
        $display("%0t ns: %s mismatch, expected %02h, actual %02h", $time, what, exp_val,
                 act_val);
    endfunction

    function void check_char(logic [i2r_pkg::SYM_W-1:0] symbol, logic last, logic error);
      numeral_char_t want;
      if (owed.size() == 0) begin
        fails++;
        reports++;
        if (reports <= REPORT_CAP)
          $display("%0t ns: unexpected character, expected none, actual %02h last %b err %b",
                   $time, symbol, last, error);
        return;
      end
      want = owed.pop_front();
      if (symbol !== want.symbol) complain("symbol", int'(want.symbol), int'(symbol));
      if (last !== want.last) complain("last", int'(want.last), int'(last));
      if (error !== want.error) complain("error", int'(want.error), int'(error));
    endfunction
  endclass

  logic                        clk;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_stall;
  logic [i2r_pkg::VALUE_W-1:0] in_value;
  logic                        out_valid;
  logic                        out_stall;
  logic [i2r_pkg::SYM_W-1:0]   out_symbol;
  logic                        out_last;
  logic                        out_error;

  numeral_board board = new();

  // idling controls, set by the stimulus process; the receiver clears hold_off_req
  bit gaps_on = 1'b0;
  bit stalls_on = 1'b0;
  bit hold_off_req = 1'b0;

  int cycles = 0;

  integer_to_roman_numeral DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_value  (in_value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_symbol(out_symbol),
    .out_last  (out_last),
    .out_error (out_error)
  );

  // free-running clock, 12 ns period
  initial begin
    clk = 1'b0;
    forever #(CLK_HALF) clk = ~clk;
  end

  // watchdog on the cycle count
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t ns: timeout, %0d characters still owed", $time, board.owed.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result channel monitor, sampled at the rising edge
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_char(out_symbol, out_last, out_error);
  end

  // receiver stall pattern: short and long bursts, a long hold-off on request
  initial begin : receiver_stall
    int run_left;
    bit level;
    run_left = 0;
    level = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        // hold off long enough for the input side to back up
        out_stall = 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_off_req = 1'b0;
        run_left = 0;
      end else if (!stalls_on) begin
        out_stall = 1'b0;
      end else begin
        if (run_left == 0) begin
          level = ($urandom_range(0, 2) == 0);
          run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50)
                                                 : $urandom_range(1, 4);
        end
        out_stall = level;
        run_left--;
      end
    end
  end

  // sender gap length: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 9);
    if (r < 6) return 0;
    if (r < 9) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // mostly digit-built values in range, plus uniform and out-of-range noise
  function automatic logic [i2r_pkg::VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 19))
      0, 1: return ($urandom_range(0, 1) == 0) ? 12'd0 : 12'($urandom_range(4000, 4095));
      2, 3, 4: return 12'($urandom_range(0, 4095));
      default: return 12'($urandom_range(0, 3) * 1000 + $urandom_range(0, 9) * 100 +
                          $urandom_range(0, 9) * 10 + $urandom_range(0, 9));
    endcase
  endfunction

  // offer one item after some idle cycles, hold it until accepted
  task automatic send_value(input logic [i2r_pkg::VALUE_W-1:0] v, input int gap);
    int i;
    for (i = 0; i < gap; i++) begin
      @(negedge clk);
      in_valid = 1'b0;
      in_value = 12'($urandom);
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_value = v;
    do @(posedge clk); while (in_stall);
    board.note_value(v);
  endtask

  initial begin : stimulus
    logic [i2r_pkg::VALUE_W-1:0] corner[];
    int i;
    int seg;

    corner = {
      12'd0, 12'd1, 12'd4, 12'd5, 12'd9, 12'd10, 12'd14, 12'd40, 12'd49, 12'd90,
      12'd99, 12'd400, 12'd444, 12'd900, 12'd999, 12'd1000, 12'd1994, 12'd2222,
      12'd3444, 12'd3888, 12'd3999, 12'd4000, 12'd4095, 12'd2048
    };

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_value = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed corners back to back: range ends, subtractive fours and nines,
    // zero digits, the longest numeral, every value bit high and low
    foreach (corner[k]) send_value(corner[k], 0);

    // random values with idling on both sides
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    for (i = 0; i < 120; i++) send_value(pick_value(), pick_gap());

    // back-pressure: receiver holds off while the sender keeps offering
    gaps_on = 1'b0;
    hold_off_req = 1'b1;
    for (i = 0; i < 30; i++) send_value(pick_value(), 0);

    // remaining random segments with mixed idling, some stretches without any
    for (seg = 0; seg < 4; seg++) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      stalls_on = ($urandom_range(0, 3) != 0);
      for (i = 0; i < 49; i++) send_value(pick_value(), pick_gap());
    end

    @(negedge clk);
    in_valid = 1'b0;

    // let the block drain, the watchdog bounds this
    while (board.owed.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (board.fails == 0 && board.owed.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0t ns: %0d mismatches, %0d characters still owed", $time, board.fails,
               board.owed.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
